>>> hdl/lkv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkv_pkg: shared types and constants of the LRU key/value cache.
// Sizes of the entry store, request codes and the per-request update plan.
// ----------------------------------------------------------------------------
package lkv_pkg;

	// Entry store size and derived widths.
	localparam int MAX_ENTRIES = 16;
	localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int WORD_W      = 32;
	localparam int CAP_W       = 5;

	// Capacity register value after reset.
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	// Request codes carried on the input sideband.
	localparam logic MODE_GET = 1'b0;
	localparam logic MODE_PUT = 1'b1;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [IDX_W-1:0]  rank_t;
	typedef logic [CNT_W-1:0]  count_t;
	typedef logic [CAP_W-1:0]  cap_t;

	// One request as held in the input stage.
	typedef struct packed {
		logic  mode;
		word_t key;
		word_t value;
	} lkv_req_t;

	// What the current request does to the entry store.
	typedef struct packed {
		logic  hit;       // key found in a valid entry
		rank_t slot;      // entry that is read, touched or written
		logic  touch;     // make slot the most recent
		logic  alloc;     // fill a free slot as a new entry
		logic  wr_key;    // write key into slot
		logic  wr_value;  // write value into slot
	} lkv_plan_t;

endpackage
`default_nettype wire

>>> hdl/lkv_lookup.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkv_lookup: parallel key match and slot selection.
// Compares the request key against every entry, finds the least recent and
// the lowest free slot, and decides how the request updates the store.
// ----------------------------------------------------------------------------
module lkv_lookup import lkv_pkg::*; (
	input  wire lkv_req_t                 req,
	input  wire cap_t                     capacity,
	input  wire logic  [MAX_ENTRIES-1:0]  valid,
	input  wire word_t [MAX_ENTRIES-1:0]  keys,
	input  wire rank_t [MAX_ENTRIES-1:0]  ranks,
	input  wire count_t                   used,
	output lkv_plan_t                     plan
);

	logic [MAX_ENTRIES-1:0] match;
	logic                   hit;
	rank_t                  hit_idx;
	rank_t                  oldest_idx;
	rank_t                  free_idx;
	cap_t                   eff_cap;
	count_t                 used_m1;
	logic                   full;
	logic                   is_put;

	// Capacity zero acts as one; values above the store size saturate.
	always_comb begin
		eff_cap = capacity;
		if (capacity == '0) begin
			eff_cap = CAP_W'(1);
		end else if (capacity > CAP_W'(MAX_ENTRIES)) begin
			eff_cap = CAP_W'(MAX_ENTRIES);
		end
	end

	assign used_m1 = used - CNT_W'(1);
	assign full    = CAP_W'(used) >= eff_cap;
	assign is_put  = (req.mode == MODE_PUT);

	// Key compare per entry and lowest-index encoders for hit, victim and free slot.
	// Valid ranks form a permutation, so the least recent entry holds rank used-1.
	always_comb begin
		hit_idx    = '0;
		oldest_idx = '0;
		free_idx   = '0;
		for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
			match[i] = valid[i] && (keys[i] == req.key);
			if (match[i]) begin
				hit_idx = IDX_W'(i);
			end
			if (valid[i] && (ranks[i] == used_m1[IDX_W-1:0])) begin
				oldest_idx = IDX_W'(i);
			end
			if (!valid[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	assign hit = |match;

	// Update plan for this request.
	always_comb begin
		plan.hit      = hit;
		plan.slot     = hit ? hit_idx : (full ? oldest_idx : free_idx);
		plan.touch    = hit || (is_put && full);
		plan.alloc    = is_put && !hit && !full;
		plan.wr_key   = is_put && !hit;
		plan.wr_value = is_put;
	end

endmodule
`default_nettype wire

>>> hdl/lkv_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkv_store: entry registers of the LRU key/value cache.
// Holds keys, values, valid bits, recency ranks and the fill count, and
// applies one request's update plan when the request completes.
// ----------------------------------------------------------------------------
module lkv_store import lkv_pkg::*; (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           apply,
	input  wire lkv_req_t                 req,
	input  wire lkv_plan_t                plan,
	output logic  [MAX_ENTRIES-1:0]       valid,
	output word_t [MAX_ENTRIES-1:0]       keys,
	output rank_t [MAX_ENTRIES-1:0]       ranks,
	output count_t                        used,
	output word_t                         slot_value
);

	logic  [MAX_ENTRIES-1:0] valid_q;
	word_t [MAX_ENTRIES-1:0] keys_q;
	word_t [MAX_ENTRIES-1:0] values_q;
	rank_t [MAX_ENTRIES-1:0] ranks_q;
	count_t                  used_q;
	rank_t [MAX_ENTRIES-1:0] ranks_nxt;
	rank_t                   old_rank;

	assign old_rank   = ranks_q[plan.slot];
	assign slot_value = values_q[plan.slot];

	// Recency update: a touch ages the entries newer than the slot, an
	// allocation ages every valid entry; the slot itself becomes the newest.
	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			ranks_nxt[i] = ranks_q[i];
			if (plan.touch && valid_q[i] && (ranks_q[i] < old_rank)) begin
				ranks_nxt[i] = ranks_q[i] + IDX_W'(1);
			end
			if (plan.alloc && valid_q[i]) begin
				ranks_nxt[i] = ranks_q[i] + IDX_W'(1);
			end
			if ((plan.touch || plan.alloc) && (plan.slot == IDX_W'(i))) begin
				ranks_nxt[i] = '0;
			end
		end
	end

	// Control state: valid bits, ranks and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ranks_q <= '0;
			used_q  <= '0;
		end else if (apply) begin
			ranks_q <= ranks_nxt;
			if (plan.alloc) begin
				valid_q[plan.slot] <= 1'b1;
				used_q             <= used_q + CNT_W'(1);
			end
		end
	end

	// Payload: keys and values, written only by puts.
	always_ff @(posedge clk) begin
		if (apply && plan.wr_key) begin
			keys_q[plan.slot] <= req.key;
		end
		if (apply && plan.wr_value) begin
			values_q[plan.slot] <= req.value;
		end
	end

	assign valid = valid_q;
	assign keys  = keys_q;
	assign ranks = ranks_q;
	assign used  = used_q;

endmodule
`default_nettype wire

>>> hdl/lru_key_value_cache_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_key_value_cache_core: fully associative key/value cache with LRU
// replacement. Gets return the stored value or all ones; puts update or insert.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Payload
// s_*      in   tuser: mode (0 get, 1 put); tdata: lookup_key [31:0], store_value [63:32]
// m_*      out  tuser: hit; tdata: read_value [31:0]
// cfg_*    in   capacity_in_use, 5 bits, written when cfg_we is high
//
// A request is registered in the input stage on transfer and completes when it
// fires, when the lookup and store update happen together; a get's result is
// then loaded into the output register. One request per cycle is sustained
// unless a held get stalls. A held get stalls only while the output register is full and
// m_tready is low; puts never wait on the output. Reset empties the cache
// and sets the capacity to 16.
// ----------------------------------------------------------------------------
module lru_key_value_cache_core import lkv_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [63:0] s_tdata,   // lookup_key [31:0], store_value [63:32]
	input  wire  [0:0]  s_tuser,   // mode [0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,   // read_value [31:0]
	output logic [0:0]  m_tuser,   // hit [0]
	input  wire         cfg_we,
	input  wire  [4:0]  cfg_wdata
);

	cap_t       cap_q;
	lkv_req_t   req_s1;
	logic       valid_s1;
	logic       out_valid_q;
	word_t      out_data_q;
	logic       out_hit_q;
	logic       fire;
	logic       is_get;
	lkv_plan_t  plan;

	logic  [MAX_ENTRIES-1:0] valid;
	word_t [MAX_ENTRIES-1:0] keys;
	rank_t [MAX_ENTRIES-1:0] ranks;
	count_t                  used;
	word_t                   slot_value;

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// The held request completes unless it is a get facing a full output.
	assign is_get   = (req_s1.mode == MODE_GET);
	assign fire     = valid_s1 && (!is_get || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || fire;

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1.mode  <= s_tuser[0];
			req_s1.key   <= s_tdata[31:0];
			req_s1.value <= s_tdata[63:32];
		end
	end

	lkv_lookup u_lookup (
		.req      (req_s1),
		.capacity (cap_q),
		.valid    (valid),
		.keys     (keys),
		.ranks    (ranks),
		.used     (used),
		.plan     (plan)
	);

	lkv_store u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.apply      (fire),
		.req        (req_s1),
		.plan       (plan),
		.valid      (valid),
		.keys       (keys),
		.ranks      (ranks),
		.used       (used),
		.slot_value (slot_value)
	);

	// Output register: loaded by a completing get, cleared on transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && is_get) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && is_get) begin
			out_hit_q  <= plan.hit;
			out_data_q <= plan.hit ? slot_value : '1;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_data_q;
	assign m_tuser[0] = out_hit_q;

	// The fill count always equals the number of valid entries.
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid) == int'(used))
		else $error("fill count differs from valid entry count");

	// A miss always reports all ones.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '1)
		else $error("miss result is not all ones");

	// A completing put never raises an empty output.
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && !is_get && !m_tvalid |=> !m_tvalid)
		else $error("put produced a result");

	// An allocation grows the fill count by exactly one.
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && plan.alloc |=> used == $past(used) + CNT_W'(1))
		else $error("allocation did not advance the fill count");

endmodule
`default_nettype wire
